// ===== sv/qot_pkg.sv =====
// shared types, constants and command word of the orientation tracker
package qot_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int IN_W = 16;
  localparam int IN_DW = 2 * IN_W;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = 4;
  localparam int ZW = 20;
  localparam int XW = 34;

  localparam logic signed [XW-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [ZW-1:0] ANG_PI = 20'sd205887;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd102944;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

  localparam logic [1:0] COMP_W = 2'd0;
  localparam logic [1:0] COMP_X = 2'd1;
  localparam logic [1:0] COMP_Y = 2'd2;
  localparam logic [1:0] COMP_Z = 2'd3;

  typedef enum logic [1:0] {
    A_QX,
    A_Q,
    A_T
  } a_sel_e;

  typedef enum logic [2:0] {
    B_QY,
    B_D,
    B_FWD,
    B_UP,
    B_CONJ
  } b_sel_e;

  typedef enum logic [1:0] {
    DST_D,
    DST_T,
    DST_F,
    DST_U
  } dst_e;

  typedef struct packed {
    logic              start;
    logic              cordic_step;
    logic [STEP_W-1:0] cordic_idx;
    logic              mul;
    logic              acc;
    logic              commit;
    logic              load_out;
    logic [1:0]        comp;
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    dst_e              dst;
  } cmd_t;

endpackage

// ===== sv/qot_ctrl.sv =====
// sequencer: cordic iterations, quaternion product steps and output handoff
module qot_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qot_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_MUL    = 6'b000100,
    S_ACC    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  localparam logic [2:0] OP_DELTA  = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_FWD_A  = 3'd2;
  localparam logic [2:0] OP_FWD_B  = 3'd3;
  localparam logic [2:0] OP_UP_A   = 3'd4;
  localparam logic [2:0] OP_UP_B   = 3'd5;

  state_e                      state_q, state_d;
  logic [qot_pkg::STEP_W-1:0]  step_q, step_d;
  logic [2:0]                  op_q, op_d;
  logic [1:0]                  comp_q, comp_d;
  logic                        out_valid_q, out_valid_d;
  qot_pkg::cmd_t               cmd;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    op_d = op_q;
    comp_d = comp_q;
    cmd = '0;
    cmd.cordic_idx = step_q;
    cmd.comp = comp_q;
    case (op_q)
      OP_UPDATE: begin
        cmd.a_sel = qot_pkg::A_Q; cmd.b_sel = qot_pkg::B_D; cmd.dst = qot_pkg::DST_T;
      end
      OP_FWD_A: begin
        cmd.a_sel = qot_pkg::A_Q; cmd.b_sel = qot_pkg::B_FWD; cmd.dst = qot_pkg::DST_T;
      end
      OP_FWD_B: begin
        cmd.a_sel = qot_pkg::A_T; cmd.b_sel = qot_pkg::B_CONJ; cmd.dst = qot_pkg::DST_F;
      end
      OP_UP_A: begin
        cmd.a_sel = qot_pkg::A_Q; cmd.b_sel = qot_pkg::B_UP; cmd.dst = qot_pkg::DST_T;
      end
      OP_UP_B: begin
        cmd.a_sel = qot_pkg::A_T; cmd.b_sel = qot_pkg::B_CONJ; cmd.dst = qot_pkg::DST_U;
      end
      default: begin
        cmd.a_sel = qot_pkg::A_QX; cmd.b_sel = qot_pkg::B_QY; cmd.dst = qot_pkg::DST_D;
      end
    endcase
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.start = 1'b1;
          step_d = '0;
          state_d = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == qot_pkg::STEP_W'(qot_pkg::CORDIC_STEPS - 1)) begin
          op_d = OP_DELTA;
          comp_d = qot_pkg::COMP_W;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        comp_d = comp_q + 1'b1;
        if (comp_q != qot_pkg::COMP_Z) begin
          state_d = S_MUL;
        end else if (op_q == OP_UPDATE) begin
          state_d = S_COMMIT;
        end else if (op_q == OP_UP_B) begin
          state_d = S_DONE;
        end else begin
          op_d = op_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        op_d = OP_FWD_A;
        state_d = S_MUL;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      op_q <= OP_DELTA;
      comp_q <= qot_pkg::COMP_W;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      op_q <= op_d;
      comp_q <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o = cmd;

endmodule

// ===== sv/qot_dp.sv =====
// datapath: two cordic lanes, four-term quaternion product unit, state and output words
module qot_dp #(
  parameter int COMPONENT_WIDTH = qot_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qot_pkg::cmd_t                cmd_i,
  input  logic [qot_pkg::IN_DW-1:0]    in_data_i,
  output logic [10*COMPONENT_WIDTH-1:0] out_data_o
);

  localparam int W = COMPONENT_WIDTH;
  localparam int FRAC = W - 2;
  localparam int OW = W + 1;
  localparam int PW = 2 * OW;
  localparam int SW = PW + 2;
  localparam int XW = qot_pkg::XW;
  localparam int ZW = qot_pkg::ZW;
  localparam int S = 32 - W;
  localparam int SR = (S == 0) ? 0 : S - 1;
  localparam logic signed [XW-1:0] QRND = (S == 0) ? '0 : signed'(XW'(1) << SR);
  localparam logic signed [SW-1:0] RND =
    signed'({{(SW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
  localparam logic signed [SW-1:0] SAT_MAX = signed'({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = signed'({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
  localparam logic signed [W-1:0] ONE_Q = signed'(W'(1) << FRAC);
  localparam int IN_W_L = qot_pkg::IN_W;

  // lane 0 is the negated pitch, lane 1 the yaw
  logic signed [XW-1:0] x_q [2];
  logic signed [XW-1:0] y_q [2];
  logic signed [ZW-1:0] z_q [2];
  logic                 neg_q [2];
  logic signed [ZW-1:0] h [2];
  logic signed [OW-1:0] cs [2];
  logic signed [OW-1:0] sn [2];

  logic signed [W-1:0] q_q [4];
  logic signed [W-1:0] d_q [4];
  logic signed [W-1:0] t_q [4];
  logic signed [W-1:0] f_q [4];
  logic signed [W-1:0] u_q [4];
  logic signed [W-1:0] out_q [10];

  logic signed [OW-1:0] av [4];
  logic signed [OW-1:0] bv [4];
  logic signed [OW-1:0] ma [4];
  logic signed [OW-1:0] mb [4];
  logic signed [PW-1:0] prod_q [4];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shf;
  logic signed [W-1:0]  res;

  logic signed [IN_W_L-1:0] pitch, yaw;

  assign pitch = signed'(in_data_i[IN_W_L-1:0]);
  assign yaw = signed'(in_data_i[2*IN_W_L-1:IN_W_L]);

  // half angle in 2^-16 rad is the input times four
  always_comb begin
    logic signed [ZW-1:0] hp;
    logic signed [ZW-1:0] hy;
    hp = -signed'({{(ZW-IN_W_L-2){pitch[IN_W_L-1]}}, pitch, 2'b00});
    hy = signed'({{(ZW-IN_W_L-2){yaw[IN_W_L-1]}}, yaw, 2'b00});
    h[0] = hp;
    h[1] = hy;
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [XW-1:0] xr;
      logic signed [XW-1:0] yr;
      xr = (x_q[l] + QRND) >>> S;
      yr = (y_q[l] + QRND) >>> S;
      cs[l] = neg_q[l] ? -OW'(xr) : OW'(xr);
      sn[l] = neg_q[l] ? -OW'(yr) : OW'(yr);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.start) begin
        x_q[l] <= qot_pkg::CORDIC_K;
        y_q[l] <= '0;
        if (h[l] > qot_pkg::ANG_HALF_PI) begin
          z_q[l] <= h[l] - qot_pkg::ANG_PI;
          neg_q[l] <= 1'b1;
        end else if (h[l] < -qot_pkg::ANG_HALF_PI) begin
          z_q[l] <= h[l] + qot_pkg::ANG_PI;
          neg_q[l] <= 1'b1;
        end else begin
          z_q[l] <= h[l];
          neg_q[l] <= 1'b0;
        end
      end else if (cmd_i.cordic_step) begin
        if (!z_q[l][ZW-1]) begin
          x_q[l] <= x_q[l] - (y_q[l] >>> cmd_i.cordic_idx);
          y_q[l] <= y_q[l] + (x_q[l] >>> cmd_i.cordic_idx);
          z_q[l] <= z_q[l] - qot_pkg::ATAN_TAB[cmd_i.cordic_idx];
        end else begin
          x_q[l] <= x_q[l] + (y_q[l] >>> cmd_i.cordic_idx);
          y_q[l] <= y_q[l] - (x_q[l] >>> cmd_i.cordic_idx);
          z_q[l] <= z_q[l] + qot_pkg::ATAN_TAB[cmd_i.cordic_idx];
        end
      end
    end
  end

  // operand selection, widened by one bit so a negated minimum stays exact
  always_comb begin
    case (cmd_i.a_sel)
      qot_pkg::A_Q: for (int k = 0; k < 4; k++) av[k] = OW'(q_q[k]);
      qot_pkg::A_T: for (int k = 0; k < 4; k++) av[k] = OW'(t_q[k]);
      default: begin
        av[0] = cs[0]; av[1] = sn[0]; av[2] = '0; av[3] = '0;
      end
    endcase
    case (cmd_i.b_sel)
      qot_pkg::B_D: for (int k = 0; k < 4; k++) bv[k] = OW'(d_q[k]);
      qot_pkg::B_FWD: begin
        bv[0] = '0; bv[1] = '0; bv[2] = OW'(ONE_Q); bv[3] = '0;
      end
      qot_pkg::B_UP: begin
        bv[0] = '0; bv[1] = '0; bv[2] = '0; bv[3] = OW'(ONE_Q);
      end
      qot_pkg::B_CONJ: begin
        bv[0] = OW'(q_q[0]);
        for (int k = 1; k < 4; k++) bv[k] = -OW'(q_q[k]);
      end
      default: begin
        bv[0] = cs[1]; bv[1] = '0; bv[2] = sn[1]; bv[3] = '0;
      end
    endcase
  end

  // term pairing of the hamilton product for the selected component
  always_comb begin
    case (cmd_i.comp)
      qot_pkg::COMP_X: begin
        ma[0] = av[0]; mb[0] = bv[1]; ma[1] = av[1]; mb[1] = bv[0];
        ma[2] = av[2]; mb[2] = bv[3]; ma[3] = av[3]; mb[3] = bv[2];
      end
      qot_pkg::COMP_Y: begin
        ma[0] = av[0]; mb[0] = bv[2]; ma[1] = av[2]; mb[1] = bv[0];
        ma[2] = av[3]; mb[2] = bv[1]; ma[3] = av[1]; mb[3] = bv[3];
      end
      qot_pkg::COMP_Z: begin
        ma[0] = av[0]; mb[0] = bv[3]; ma[1] = av[3]; mb[1] = bv[0];
        ma[2] = av[1]; mb[2] = bv[2]; ma[3] = av[2]; mb[3] = bv[1];
      end
      default: begin
        for (int k = 0; k < 4; k++) begin
          ma[k] = av[k]; mb[k] = bv[k];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int k = 0; k < 4; k++) begin
        if (k == 3 || (k != 0 && cmd_i.comp == qot_pkg::COMP_W)) begin
          prod_q[k] <= -(ma[k] * mb[k]);
        end else begin
          prod_q[k] <= ma[k] * mb[k];
        end
      end
    end
  end

  // exact four-term sum, round half up, saturate
  always_comb begin
    sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]) + RND;
    shf = sum >>> FRAC;
    if (shf > SAT_MAX) begin
      res = SAT_MAX[W-1:0];
    end else if (shf < SAT_MIN) begin
      res = SAT_MIN[W-1:0];
    end else begin
      res = shf[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= ONE_Q;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
    end else if (cmd_i.commit) begin
      for (int k = 0; k < 4; k++) q_q[k] <= t_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      case (cmd_i.dst)
        qot_pkg::DST_D: d_q[cmd_i.comp] <= res;
        qot_pkg::DST_T: t_q[cmd_i.comp] <= res;
        qot_pkg::DST_F: f_q[cmd_i.comp] <= res;
        default: u_q[cmd_i.comp] <= res;
      endcase
    end
    if (cmd_i.load_out) begin
      for (int k = 0; k < 4; k++) out_q[k] <= q_q[k];
      for (int k = 0; k < 3; k++) begin
        out_q[4+k] <= f_q[k+1];
        out_q[7+k] <= u_q[k+1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 10; k++) out_data_o[k*W +: W] = out_q[k];
  end

endmodule

// ===== sv/quaternion_orientation_tracker_core.sv =====
// top level of the quaternion orientation tracker
// Holds an orientation quaternion (identity after reset) and, for each input word of pitch
// and yaw increments, builds the half-angle x and y rotations with two 16-step cordic lanes,
// multiplies them, right-multiplies the stored orientation and rotates the forward and up
// vectors through it. Each word takes one load, 16 cordic iterations, six quaternion
// products of four components, each a multiply and an accumulate step in the shared
// four-multiplier product unit, a commit of the new orientation and a load of the output
// register. The next word is taken while a finished result still waits.
// Components are Q2.(COMPONENT_WIDTH-2), rounded half up and saturated, never renormalized.
module quaternion_orientation_tracker_core #(
  parameter int COMPONENT_WIDTH = qot_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pitch_delta, yaw_delta
  input  logic [qot_pkg::IN_DW-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // orient_w, orient_x, orient_y, orient_z, forward_x, forward_y, forward_z, up_x, up_y, up_z
  output logic [((10*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_W = 10 * COMPONENT_WIDTH;
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

  qot_pkg::cmd_t     cmd;
  logic [OUT_W-1:0]  out_data;

  qot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  qot_dp #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .out_data_o(out_data)
  );

  assign m_axis_tdata = OUT_DW'(out_data);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while previous word still in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded over an untaken result");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (s_axis_tready && s_axis_tvalid))
    else $error("cordic started without an accepted word");

endmodule

// ===== tb/tb_quaternion_orientation_tracker_core.sv =====
// testbench of the quaternion orientation tracker: directed table, then random words
module tb_quaternion_orientation_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FRAC = CW - 2;
  localparam int OW = ((10 * CW + 7) / 8) * 8;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CW - 1));

  typedef logic signed [63:0] q_t [4];

  typedef struct {
    logic [15:0] pitch;
    logic [15:0] yaw;
    bit          known;
    logic [OW-1:0] word;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [qot_pkg::IN_DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;

  quaternion_orientation_tracker_core #(.COMPONENT_WIDTH(CW)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic signed [63:0] attitude [4];
  logic [OW-1:0] pending_words [$];
  int errors = 0;
  int recv_idle_pct = 0;

  // exact four-term sum, rounded half up once, then saturated
  function automatic logic signed [63:0] round_sum(logic signed [127:0] a, logic signed [127:0] b,
                                                    logic signed [127:0] c, logic signed [127:0] d);
    logic signed [127:0] s;
    s = a + b + c + d + (128'sd1 <<< (FRAC - 1));
    s = s >>> FRAC;
    if (s > CMAX) return CMAX;
    if (s < CMIN) return CMIN;
    return s[63:0];
  endfunction

  function automatic void quat_mul(input q_t a, input q_t b, output q_t r);
    r[0] = round_sum(a[0]*b[0], -(a[1]*b[1]), -(a[2]*b[2]), -(a[3]*b[3]));
    r[1] = round_sum(a[0]*b[1], a[1]*b[0], a[2]*b[3], -(a[3]*b[2]));
    r[2] = round_sum(a[0]*b[2], a[2]*b[0], a[3]*b[1], -(a[1]*b[3]));
    r[3] = round_sum(a[0]*b[3], a[3]*b[0], a[1]*b[2], -(a[2]*b[1]));
  endfunction

  function automatic void half_sincos(input logic signed [63:0] h,
                                      output logic signed [63:0] s, output logic signed [63:0] c);
    logic signed [63:0] x, y, z, dx, dy;
    bit flip;
    flip = 0;
    if (h > qot_pkg::ANG_HALF_PI) begin
      h = h - qot_pkg::ANG_PI; flip = 1;
    end else if (h < -qot_pkg::ANG_HALF_PI) begin
      h = h + qot_pkg::ANG_PI; flip = 1;
    end
    x = qot_pkg::CORDIC_K; y = 0; z = h;
    for (int i = 0; i < qot_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= qot_pkg::ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += qot_pkg::ATAN_TAB[i];
      end
    end
    x = (x + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
    y = (y + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
    if (flip) begin
      x = -x; y = -y;
    end
    s = y; c = x;
  endfunction

  function automatic void spin_vector(input q_t q, input q_t v, output q_t r);
    q_t t, cj;
    cj[0] = q[0]; cj[1] = -q[1]; cj[2] = -q[2]; cj[3] = -q[3];
    quat_mul(q, v, t);
    quat_mul(t, cj, r);
  endfunction

  function automatic logic [OW-1:0] advance_attitude(logic [15:0] pitch, logic [15:0] yaw);
    logic signed [63:0] sx, cx, sy, cy;
    q_t qx, qy, d, cur, nq, fv, uv, rf, ru;
    logic [OW-1:0] w;
    half_sincos(-($signed({{48{pitch[15]}}, pitch}) * 4), sx, cx);
    half_sincos($signed({{48{yaw[15]}}, yaw}) * 4, sy, cy);
    qx = '{cx, sx, 0, 0};
    qy = '{cy, 0, sy, 0};
    quat_mul(qx, qy, d);
    for (int k = 0; k < 4; k++) cur[k] = attitude[k];
    quat_mul(cur, d, nq);
    for (int k = 0; k < 4; k++) attitude[k] = nq[k];
    fv = '{0, 0, 64'sd1 <<< FRAC, 0};
    uv = '{0, 0, 0, 64'sd1 <<< FRAC};
    spin_vector(nq, fv, rf);
    spin_vector(nq, uv, ru);
    w = '0;
    for (int k = 0; k < 4; k++) w[k*CW +: CW] = nq[k][CW-1:0];
    for (int k = 0; k < 3; k++) begin
      w[(4+k)*CW +: CW] = rf[k+1][CW-1:0];
      w[(7+k)*CW +: CW] = ru[k+1][CW-1:0];
    end
    return w;
  endfunction

  // receiver: random stalls, compare against oldest expectation
  always @(posedge clk_i) begin
    logic [OW-1:0] exp_w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        for (int k = 0; k < 10; k++)
          if (exp_w[k*CW +: CW] !== m_axis_tdata[k*CW +: CW]) begin
            $display("%0t: field %0d expected %h actual %h", $time, k,
                     exp_w[k*CW +: CW], m_axis_tdata[k*CW +: CW]);
            errors++;
          end
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // called at a falling edge; valid stays high into the next word when there is no idle
  task automatic send_word(logic [15:0] pitch, logic [15:0] yaw, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {yaw, pitch};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_words.push_back(advance_attitude(pitch, yaw));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1, 2: return 16'($urandom_range(25736 * 2) - 25736);
      default: return 16'($urandom_range(800) - 400);
    endcase
  endfunction

  row_t dir_rows [$];
  logic [OW-1:0] ident_w;

  initial begin
    row_t r;
    int sender_idle;
    logic [15:0] vals [12] = '{16'h0000, 16'h6488, 16'h9b78, 16'h7fff, 16'h8000, 16'hffff,
                                16'h0001, 16'h3244, 16'hcdbc, 16'h3245, 16'h4000, 16'hc000};
    // zero step from identity keeps identity, forward (0,1,0), up (0,0,1)
    ident_w = '0;
    ident_w[0 +: CW] = 16'h4000;
    ident_w[5*CW +: CW] = 16'h4000;
    ident_w[9*CW +: CW] = 16'h4000;
    r = '{16'h0000, 16'h0000, 1, ident_w};
    dir_rows.push_back(r);
    for (int i = 0; i < 12; i++) begin
      r = '{vals[i], 16'h0000, 0, '0};
      dir_rows.push_back(r);
      r = '{16'h0000, vals[(i + 5) % 12], 0, '0};
      dir_rows.push_back(r);
    end

    attitude[0] = 64'sd1 <<< FRAC;
    attitude[1] = 0; attitude[2] = 0; attitude[3] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].pitch, dir_rows[i].yaw, 0);
      if (dir_rows[i].known) begin
        pending_words.pop_back();
        pending_words.push_back(dir_rows[i].word);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle = (ph == 0) ? 36 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < 460; n++) begin
        send_word(rand_angle(), rand_angle(), sender_idle);
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_idle_pct = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("tb_quaternion_orientation_tracker_core OK");
    else
      $display("tb_quaternion_orientation_tracker_core NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_quaternion_orientation_tracker_core NOT OK");
    $finish;
  end

endmodule
